@@ rtl/core/dbl_pkg.sv @@
// ----------------------------------------------------------------------------
// dbl_pkg
// Types, constants and register codes shared by the depth background labeler.
// ----------------------------------------------------------------------------
package dbl_pkg;

  localparam int unsigned DBL_PIXELS = 307200;

  localparam int unsigned IDX_W   = 19;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned LABEL_W = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DEPTH_W-1:0] BG_RESET_MM = 16'd100;

  localparam logic [DEPTH_W-1:0] FAR_LIMIT_RESET = 16'd65535;
  localparam logic [DEPTH_W-1:0] MARGIN_RESET    = 16'd20;
  localparam logic [CNT_W-1:0]   CONFIRM_RESET   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM   = 2'd2;

  // label codes
  localparam logic [LABEL_W-1:0] LABEL_FOREGROUND = 2'd0;
  localparam logic [LABEL_W-1:0] LABEL_NO_SIGNAL  = 2'd1;
  localparam logic [LABEL_W-1:0] LABEL_TOO_FAR    = 2'd2;
  localparam logic [LABEL_W-1:0] LABEL_BACKGROUND = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [DEPTH_W-1:0] depth_mm;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [DEPTH_W-1:0] background_mm;
  } out_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] far_limit_mm;
    logic [DEPTH_W-1:0] margin_mm;
    logic [CNT_W-1:0]   confirm_count;
  } cfg_t;

  // one memory word per pixel
  typedef struct packed {
    logic [DEPTH_W-1:0] background;
    logic [DEPTH_W-1:0] candidate;
    logic [CNT_W-1:0]   run_count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    background: BG_RESET_MM,
    candidate:  '0,
    run_count:  '0
  };

endpackage

@@ rtl/core/dbl_ram.sv @@
// ----------------------------------------------------------------------------
// dbl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dbl_update.sv @@
// ----------------------------------------------------------------------------
// dbl_update
// Per-pixel model update and labelling for one depth sample.
// ----------------------------------------------------------------------------
module dbl_update (
  input  dbl_pkg::cfg_t                 cfg_i,
  input  dbl_pkg::entry_t               entry_i,
  input  logic [dbl_pkg::DEPTH_W-1:0]   depth_i,
  output dbl_pkg::entry_t               entry_o,
  output logic                          we_o,
  output logic [dbl_pkg::LABEL_W-1:0]   label_o
);
  import dbl_pkg::*;

  logic [CNT_W-1:0]   need;
  logic [CNT_W-1:0]   cnt;
  logic [DEPTH_W-1:0] cand;
  logic [DEPTH_W-1:0] bg;
  logic               deeper;
  logic signed [DEPTH_W+1:0] thresh;
  logic signed [DEPTH_W+1:0] depth_s;

  always_comb begin
    need   = (cfg_i.confirm_count == '0) ? CNT_W'(1) : cfg_i.confirm_count;
    deeper = depth_i > entry_i.background;
    cand   = entry_i.candidate;
    cnt    = entry_i.run_count;
    bg     = entry_i.background;

    if (deeper) begin
      if ((entry_i.run_count == '0) || (entry_i.candidate > depth_i)) begin
        cand = depth_i;
      end
      cnt = entry_i.run_count + CNT_W'(1);
    end else begin
      cnt = '0;
    end

    // run confirmed: background moves to the shallowest deeper value
    if (cnt >= need) begin
      bg  = cand;
      cnt = '0;
    end

    depth_s = signed'({2'b00, depth_i});
    thresh  = signed'({2'b00, bg}) - signed'({2'b00, cfg_i.margin_mm});

    if (depth_i == '0) begin
      we_o    = 1'b0;
      entry_o = entry_i;
      label_o = LABEL_NO_SIGNAL;
    end else begin
      we_o    = 1'b1;
      entry_o = '{background: bg, candidate: cand, run_count: cnt};
      if (depth_i > cfg_i.far_limit_mm) begin
        label_o = LABEL_TOO_FAR;
      end else if (depth_s > thresh) begin
        label_o = LABEL_BACKGROUND;
      end else begin
        label_o = LABEL_FOREGROUND;
      end
    end
  end

endmodule

@@ rtl/core/depth_background_labeler.sv @@
// ----------------------------------------------------------------------------
// depth_background_labeler
// Per-pixel maximum-depth background model with foreground labelling.
// ----------------------------------------------------------------------------
// Takes one depth pixel per clock unless the output stalls or clearing runs,
// and returns one label with the pixel's updated background depth. The
// whole model (background, candidate, run count) sits in one memory word per
// pixel; a request reads its word on acceptance, is updated in the following
// cycle and is written back as it moves into the output register, with
// forwarding when the next request hits the same pixel. Sustained rate is
// one request per cycle while the output is not stalled. After reset the
// block runs a clearing pass over every memory word and accepts no request
// during it; configuration writes are taken at any time. Indexes at or
// beyond PIXELS see the reset model and write nothing back.
module depth_background_labeler #(
  parameter int unsigned PIXELS = dbl_pkg::DBL_PIXELS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dbl_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dbl_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dbl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dbl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dbl_pkg::*;

  localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

  // configuration
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{far_limit_mm: FAR_LIMIT_RESET, margin_mm: MARGIN_RESET,
                 confirm_count: CONFIRM_RESET};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FAR_LIMIT: cfg_q.far_limit_mm  <= cfg_data_i;
        CFG_MARGIN:    cfg_q.margin_mm     <= cfg_data_i;
        CFG_CONFIRM:   cfg_q.confirm_count <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clearing pass
  logic          clear_q;
  logic [AW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_idx_q <= '0;
    end else if (clear_q) begin
      if (clr_idx_q == LAST_ADDR) begin
        clear_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + AW'(1);
      end
    end
  end

  // pipeline control
  logic   s1_valid_q;
  in_t    s1_in_q;
  logic   s1_hit_q;
  logic   fwd_q;
  entry_t fwd_entry_q;
  logic   out_valid_q;
  out_t   out_q;

  logic   s1_adv;
  logic   in_accept;
  logic   in_hit;
  logic   item_we;
  logic   fwd_d;

  entry_t ram_rdata;
  entry_t cur_entry;
  entry_t new_entry;
  logic   upd_we;
  logic [LABEL_W-1:0] upd_label;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clear_q && (!s1_valid_q || s1_adv);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_hit     = 32'(in_data_i.pixel_index) < 32'(PIXELS);
  assign item_we    = s1_adv && s1_hit_q && upd_we;
  // the write of the leaving request lands too late for this read
  assign fwd_d      = item_we && (in_data_i.pixel_index == s1_in_q.pixel_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_in_q     <= in_data_i;
      s1_hit_q    <= in_hit;
      fwd_q       <= fwd_d;
      fwd_entry_q <= new_entry;
    end
  end

  always_comb begin
    if (!s1_hit_q) begin
      cur_entry = ENTRY_RESET;
    end else if (fwd_q) begin
      cur_entry = fwd_entry_q;
    end else begin
      cur_entry = ram_rdata;
    end
  end

  dbl_update u_update (
    .cfg_i   (cfg_q),
    .entry_i (cur_entry),
    .depth_i (s1_in_q.depth_mm),
    .entry_o (new_entry),
    .we_o    (upd_we),
    .label_o (upd_label)
  );

  // model memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  assign mem_we    = clear_q || item_we;
  assign mem_waddr = clear_q ? clr_idx_q : AW'(s1_in_q.pixel_index);
  assign mem_wdata = clear_q ? ENTRY_RESET : new_entry;

  dbl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_accept && in_hit),
    .raddr_i (AW'(in_data_i.pixel_index)),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= '{label: upd_label, background_mm: new_entry.background};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !in_ready_o)
    else $error("request accepted during clearing pass");

  a_item_write_on_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clear_q) |-> (s1_valid_q && s1_adv && s1_hit_q))
    else $error("model write without a leaving request");

  a_clear_full_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_q) |-> ($past(clr_idx_q) == LAST_ADDR))
    else $error("clearing pass ended early");

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted request lost before update stage");

  a_fwd_only_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && fwd_d) |=> s1_hit_q)
    else $error("forward for an out-of-range pixel");

endmodule
